[hdl/mecc_pkg.sv]
package mecc_pkg;

  // item field widths
  localparam int POS_W   = 10;
  localparam int PAGE_W  = 3;
  localparam int TOTAL_W = 48;
  localparam int NODE_W  = 16;

  // default sizing
  localparam int DEF_NUM_VERTICES = 1024;
  localparam int DEF_NUM_PAGES    = 8;
  localparam int DEF_MAX_DEGREE   = 64;

  typedef enum logic [1:0] {
    OP_ADD,
    OP_SUB,
    OP_QUERY,
    OP_CLEAR
  } tree_op_t;

  // request to the Fenwick unit; lo is the mark position for add/sub
  typedef struct packed {
    logic              start;
    tree_op_t          op;
    logic [PAGE_W-1:0] page;
    logic [POS_W-1:0]  lo;
    logic [POS_W-1:0]  hi;
  } tree_cmd_t;

  typedef struct packed {
    logic              done;
    logic [NODE_W-1:0] sum;
  } tree_rsp_t;

  typedef struct packed {
    logic [POS_W-1:0]  lo;
    logic [POS_W-1:0]  hi;
    logic [PAGE_W-1:0] page;
  } pend_entry_t;

endpackage

[hdl/mecc_tree.sv]
module mecc_tree #(
  parameter int NUM_VERTICES = mecc_pkg::DEF_NUM_VERTICES,
  parameter int NUM_PAGES    = mecc_pkg::DEF_NUM_PAGES
) (
  input  logic                clk,
  input  logic                rst_n,
  input  mecc_pkg::tree_cmd_t cmd,
  output mecc_pkg::tree_rsp_t rsp
);
  import mecc_pkg::*;

  localparam int DEPTH = NUM_PAGES * NUM_VERTICES;
  localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int IW    = $clog2(NUM_VERTICES) + 2;
  localparam int SW    = ((AW > IW) ? AW : IW) + 1;

  typedef enum logic [1:0] {
    T_IDLE,
    T_UPD,
    T_QRY,
    T_CLR
  } tstate_t;

  tstate_t           state_r;
  logic [AW-1:0]     base_r;
  logic [IW-1:0]     i_r;
  logic [POS_W-1:0]  lo_r;
  logic              sub_r;
  logic              phase_r;
  logic              pend_r;
  logic              pend_sub_r;
  logic [AW-1:0]     wr_addr_r;
  logic [AW-1:0]     clr_addr_r;
  logic [NODE_W-1:0] acc_r;
  logic              done_r;

  logic [NODE_W-1:0] mem [DEPTH];
  logic [NODE_W-1:0] rdata_r;

  logic              re;
  logic              we;
  logic [AW-1:0]     waddr;
  logic [NODE_W-1:0] wdata;
  logic [SW-1:0]     addr_sum;
  logic [AW-1:0]     node_addr;
  logic [IW-1:0]     low_bit;

  // Fenwick index i maps to node base + i - 1
  assign addr_sum  = SW'(base_r) + SW'(i_r) - SW'(1);
  assign node_addr = addr_sum[AW-1:0];
  assign low_bit   = i_r & (~i_r + IW'(1));

  always_comb begin
    re    = ((state_r == T_UPD) && (i_r <= IW'(NUM_VERTICES))) ||
            ((state_r == T_QRY) && (i_r != '0));
    we    = ((state_r == T_UPD) && pend_r) || (state_r == T_CLR);
    waddr = (state_r == T_CLR) ? clr_addr_r : wr_addr_r;
    wdata = (state_r == T_CLR) ? '0 :
            rdata_r + (sub_r ? {NODE_W{1'b1}} : NODE_W'(1));
  end

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[node_addr];
    end
  end

  // one node read per cycle; the write-back of the previous node overlaps
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= T_IDLE;
      pend_r  <= 1'b0;
      done_r  <= 1'b0;
    end else begin
      // walk finished: last write-back done, or last cleared node
      done_r <= ((state_r == T_UPD) && !re && !pend_r) ||
                ((state_r == T_QRY) && !re && phase_r && !pend_r) ||
                ((state_r == T_CLR) && (clr_addr_r == AW'(DEPTH - 1)));
      case (state_r)
        T_IDLE: begin
          if (cmd.start) begin
            base_r <= AW'(int'(cmd.page) * NUM_VERTICES);
            pend_r <= 1'b0;
            case (cmd.op)
              OP_ADD, OP_SUB: begin
                i_r     <= IW'(cmd.lo) + IW'(1);
                sub_r   <= (cmd.op == OP_SUB);
                state_r <= T_UPD;
              end
              OP_QUERY: begin
                // prefix(hi-1) minus prefix(lo)
                i_r     <= IW'(cmd.hi);
                lo_r    <= cmd.lo;
                phase_r <= 1'b0;
                acc_r   <= '0;
                state_r <= T_QRY;
              end
              OP_CLEAR: begin
                clr_addr_r <= '0;
                state_r    <= T_CLR;
              end
              default: state_r <= T_IDLE;
            endcase
          end
        end
        T_UPD: begin
          if (re) begin
            wr_addr_r <= node_addr;
            pend_r    <= 1'b1;
            i_r       <= i_r + low_bit;
          end else begin
            pend_r <= 1'b0;
            if (!pend_r) begin
              state_r <= T_IDLE;
            end
          end
        end
        T_QRY: begin
          if (pend_r) begin
            acc_r <= pend_sub_r ? acc_r - rdata_r : acc_r + rdata_r;
          end
          if (re) begin
            pend_r     <= 1'b1;
            pend_sub_r <= phase_r;
            i_r        <= i_r - low_bit;
          end else if (!phase_r) begin
            phase_r <= 1'b1;
            i_r     <= IW'(lo_r) + IW'(1);
            pend_r  <= 1'b0;
          end else begin
            pend_r <= 1'b0;
            if (!pend_r) begin
              state_r <= T_IDLE;
            end
          end
        end
        T_CLR: begin
          if (clr_addr_r == AW'(DEPTH - 1)) begin
            state_r <= T_IDLE;
          end else begin
            clr_addr_r <= clr_addr_r + AW'(1);
          end
        end
        default: state_r <= T_IDLE;
      endcase
    end
  end

  assign rsp.done = done_r;
  assign rsp.sum  = acc_r;

endmodule

[hdl/multipage_edge_crossing_counter_top.sv]
// An item with no vertex end is handled by one node walk through the
//   single-read-port Fenwick memory.
// A vertex or graph end adds two prefix walks per queued edge, plus posting of
//   the result, which waits while the previous result is held by a stall; one
//   item at a time.
// Reset (sync, active low) and every graph end start a clearing sweep of all
//   NUM_PAGES*NUM_VERTICES tree nodes, during which no item is accepted.
module multipage_edge_crossing_counter_top #(
  parameter int NUM_VERTICES = mecc_pkg::DEF_NUM_VERTICES,
  parameter int NUM_PAGES    = mecc_pkg::DEF_NUM_PAGES,
  parameter int MAX_DEGREE   = mecc_pkg::DEF_MAX_DEGREE
) (
  input  logic                         clk,
  input  logic                         rst_n,
  // item channel
  input  logic                         in_valid,
  output logic                         in_stall,
  input  logic [mecc_pkg::POS_W-1:0]   in_pos_lo,
  input  logic [mecc_pkg::POS_W-1:0]   in_pos_hi,
  input  logic [mecc_pkg::PAGE_W-1:0]  in_page,
  input  logic                         in_closing,
  input  logic                         in_last_of_vertex,
  input  logic                         in_last_of_graph,
  // result channel
  output logic                         out_valid,
  input  logic                         out_stall,
  output logic [mecc_pkg::TOTAL_W-1:0] out_crossing_total,
  output logic                         out_graph_done
);
  import mecc_pkg::*;

  localparam int QW = (MAX_DEGREE > 1) ? $clog2(MAX_DEGREE) : 1;
  localparam int CW = $clog2(MAX_DEGREE + 1);

  typedef enum logic [3:0] {
    S_INIT,       // kick off tree clear
    S_CLR_WAIT,
    S_IDLE,       // ready for an item
    S_UPD_GO,     // add or remove the mark
    S_UPD_WAIT,
    S_FETCH,      // read next queued close
    S_LOAD,       // start its range query
    S_QRY_WAIT,
    S_EMIT        // hand the total to the output register
  } state_t;

  state_t             state_r;
  logic [POS_W-1:0]   lo_r;
  logic [POS_W-1:0]   hi_r;
  logic [PAGE_W-1:0]  page_r;
  logic               closing_r;
  logic               last_v_r;
  logic               last_g_r;
  logic [CW-1:0]      count_r;
  logic [CW-1:0]      k_r;
  logic [TOTAL_W-1:0] total_r;
  logic               out_valid_r;
  logic [TOTAL_W-1:0] out_total_r;
  logic               out_done_r;

  // queue of edges closed at the current vertex
  pend_entry_t        pend_mem [MAX_DEGREE];
  pend_entry_t        pend_rd_r;

  logic [POS_W-1:0]   lo_sw;
  logic [POS_W-1:0]   hi_sw;
  logic               item_ok;
  logic [POS_W:0]     lo_p1;
  logic               span_ok;
  logic               q_push;
  logic               q_rd;
  logic               out_free;
  logic [TOTAL_W:0]   sum_wide;

  tree_cmd_t          tcmd;
  tree_rsp_t          trsp;

  assign in_stall = (state_r != S_IDLE);

  // endpoints may arrive swapped
  assign lo_sw   = (in_pos_lo > in_pos_hi) ? in_pos_hi : in_pos_lo;
  assign hi_sw   = (in_pos_lo > in_pos_hi) ? in_pos_lo : in_pos_hi;
  // out-of-range page or position leaves tree and queue untouched
  assign item_ok = (int'(in_page) < NUM_PAGES) && (int'(hi_sw) < NUM_VERTICES);

  // adjacent endpoints enclose nothing
  assign lo_p1   = {1'b0, pend_rd_r.lo} + {{POS_W{1'b0}}, 1'b1};
  assign span_ok = ({1'b0, pend_rd_r.hi} > lo_p1);

  // a full queue drops the edge; its mark is still removed
  assign q_push = (state_r == S_UPD_WAIT) && trsp.done && closing_r &&
                  (count_r < CW'(MAX_DEGREE));
  assign q_rd   = (state_r == S_FETCH) && (k_r != count_r);

  assign out_free = !out_valid_r || !out_stall;
  assign sum_wide = {1'b0, total_r} + (TOTAL_W + 1)'(trsp.sum);

  always_comb begin
    tcmd.start = 1'b0;
    tcmd.op    = OP_QUERY;
    tcmd.page  = page_r;
    tcmd.lo    = lo_r;
    tcmd.hi    = hi_r;
    case (state_r)
      S_INIT: begin
        tcmd.start = 1'b1;
        tcmd.op    = OP_CLEAR;
      end
      S_UPD_GO: begin
        tcmd.start = 1'b1;
        tcmd.op    = closing_r ? OP_SUB : OP_ADD;
      end
      S_LOAD: begin
        tcmd.start = span_ok;
        tcmd.op    = OP_QUERY;
        tcmd.page  = pend_rd_r.page;
        tcmd.lo    = pend_rd_r.lo;
        tcmd.hi    = pend_rd_r.hi;
      end
      default: tcmd.start = 1'b0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (q_push) begin
      pend_mem[count_r[QW-1:0]] <= '{lo: lo_r, hi: hi_r, page: page_r};
    end
    if (q_rd) begin
      pend_rd_r <= pend_mem[k_r[QW-1:0]];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_INIT;
      count_r     <= '0;
      k_r         <= '0;
      total_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      // in S_EMIT the register is reloaded instead
      if (out_valid_r && !out_stall && (state_r != S_EMIT)) begin
        out_valid_r <= 1'b0;
      end
      case (state_r)
        S_INIT: state_r <= S_CLR_WAIT;
        S_CLR_WAIT: begin
          if (trsp.done) begin
            state_r <= S_IDLE;
          end
        end
        S_IDLE: begin
          if (in_valid) begin
            lo_r      <= lo_sw;
            hi_r      <= hi_sw;
            page_r    <= in_page;
            closing_r <= in_closing;
            last_v_r  <= in_last_of_vertex;
            last_g_r  <= in_last_of_graph;
            if (item_ok) begin
              state_r <= S_UPD_GO;
            end else if (in_last_of_vertex || in_last_of_graph) begin
              state_r <= S_FETCH;
            end
          end
        end
        S_UPD_GO: state_r <= S_UPD_WAIT;
        S_UPD_WAIT: begin
          if (trsp.done) begin
            if (q_push) begin
              count_r <= count_r + CW'(1);
            end
            state_r <= (last_v_r || last_g_r) ? S_FETCH : S_IDLE;
          end
        end
        S_FETCH: state_r <= (k_r == count_r) ? S_EMIT : S_LOAD;
        S_LOAD: begin
          if (span_ok) begin
            state_r <= S_QRY_WAIT;
          end else begin
            k_r     <= k_r + CW'(1);
            state_r <= S_FETCH;
          end
        end
        S_QRY_WAIT: begin
          if (trsp.done) begin
            // saturate on carry out of the total
            total_r <= sum_wide[TOTAL_W] ? {TOTAL_W{1'b1}} : sum_wide[TOTAL_W-1:0];
            k_r     <= k_r + CW'(1);
            state_r <= S_FETCH;
          end
        end
        S_EMIT: begin
          if (out_free) begin
            out_valid_r <= 1'b1;
            out_total_r <= total_r;
            out_done_r  <= last_g_r;
            count_r     <= '0;
            k_r         <= '0;
            if (last_g_r) begin
              // graph end: wipe total and the whole tree
              total_r <= '0;
              state_r <= S_INIT;
            end else begin
              state_r <= S_IDLE;
            end
          end
        end
        default: state_r <= S_INIT;
      endcase
    end
  end

  assign out_valid          = out_valid_r;
  assign out_crossing_total = out_total_r;
  assign out_graph_done     = out_done_r;

  mecc_tree #(
    .NUM_VERTICES (NUM_VERTICES),
    .NUM_PAGES    (NUM_PAGES)
  ) u_tree (
    .clk   (clk),
    .rst_n (rst_n),
    .cmd   (tcmd),
    .rsp   (trsp)
  );

endmodule

[hdl/mecc_checker.sv]
module mecc_checker (
  input logic                         clk,
  input logic                         rst_n,
  input logic                         in_valid,
  input logic                         in_stall,
  input logic                         in_last_of_graph,
  input logic                         out_valid,
  input logic                         out_stall,
  input logic [mecc_pkg::TOTAL_W-1:0] out_crossing_total,
  input logic                         out_graph_done
);

  // clearing sweep follows reset: no item taken right after
  a_reset_stalls: assert property (@(posedge clk) !rst_n |=> in_stall)
    else $error("item port open right after reset");

  a_reset_no_result: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("result present right after reset");

  // a graph end always keeps the block busy the next cycle
  a_graph_end_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && !in_stall && in_last_of_graph) |=> in_stall)
    else $error("item port open right after graph end item");

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_stall) |=>
      (out_valid && $stable(out_crossing_total) && $stable(out_graph_done)))
    else $error("stalled result changed or dropped");

endmodule

bind multipage_edge_crossing_counter_top mecc_checker u_mecc_checker (.*);
